FILE: hdl/ntwa_pkg.sv
// ----------------------------------------------------------------------------
// ntwa_pkg
// Shared types and codes for the neighbor table with aging: operation and
// status codes, request and response payloads, controller commands.
// ----------------------------------------------------------------------------
package ntwa_pkg;

	localparam int FUNC_W = 3;
	localparam int ID_W   = 48;
	localparam int QUAL_W = 16;
	localparam int HOPS_W = 8;
	localparam int RSSI_W = 8;
	localparam int AGE_W  = 8;
	localparam int STAT_W = 2;
	localparam int CNTO_W = 5;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_SETDIST = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

	// response status codes
	localparam logic [STAT_W-1:0] STAT_UPDATED   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ADDED     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	localparam logic [AGE_W-1:0] AGING_RELOAD_RST = 8'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [ID_W-1:0]          node_id;
		logic                     is_root;
		logic                     is_joined;
		logic [QUAL_W-1:0]        link_quality;
		logic [HOPS_W-1:0]        hop_distance;
		logic signed [RSSI_W-1:0] signal_strength;
		logic [ID_W-1:0]          parent_id;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic [HOPS_W-1:0] found_distance;
		logic [CNTO_W-1:0] removed_count;
		logic              lost_parent;
		logic [CNTO_W-1:0] entry_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

endpackage

FILE: hdl/ntwa_ctrl.sv
// ----------------------------------------------------------------------------
// ntwa_ctrl
// Sequencer: takes a request, holds the write-back until the response
// register can be loaded, and owns the response valid flag.
// ----------------------------------------------------------------------------
module ntwa_ctrl
	import ntwa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ctrl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_WB
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	// handshake decode
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && req_valid;
		cmd.commit  = (state_q == ST_WB) && (!rsp_valid_q || !rsp_stall);
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_WB;
				end
				ST_WB: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/ntwa_dpath.sv
// ----------------------------------------------------------------------------
// ntwa_dpath
// Table storage and datapath: parallel key match and expiry scan on
// capture, registered; table update and response build on commit.
// ----------------------------------------------------------------------------
module ntwa_dpath
	import ntwa_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int ID_BYTES      = 6,
	parameter int QUALITY_BYTES = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	input  req_t             req,
	input  logic             cfg_write,
	input  logic [AGE_W-1:0] cfg_data,
	output rsp_t             rsp
);

	localparam int N     = TABLE_ENTRIES;
	localparam int CNT_W = $clog2(N + 1);
	localparam logic [ID_W-1:0] ID_MASK =
		(ID_BYTES * 8 >= ID_W) ? {ID_W{1'b1}} : ((ID_W'(1) << (ID_BYTES * 8)) - ID_W'(1));
	localparam logic [QUAL_W-1:0] QUAL_MASK =
		(QUALITY_BYTES * 8 >= QUAL_W) ? {QUAL_W{1'b1}} :
		((QUAL_W'(1) << (QUALITY_BYTES * 8)) - QUAL_W'(1));

	function automatic logic [CNT_W-1:0] popcount(input logic [N-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < N; i++)
			n = n + CNT_W'(v[i]);
		return n;
	endfunction

	// table storage
	logic [N-1:0]             valid_q;
	logic [ID_W-1:0]          key_q   [N];
	logic                     root_q  [N];
	logic                     conn_q  [N];
	logic [QUAL_W-1:0]        qual_q  [N];
	logic [HOPS_W-1:0]        hops_q  [N];
	logic [RSSI_W-1:0]        rssi_q  [N];
	logic [AGE_W-1:0]         age_q   [N];
	logic [CNT_W-1:0]         cnt_q;
	logic [AGE_W-1:0]         reload_q;

	// match stage
	logic [ID_W-1:0]   key_c, parent_c;
	logic [N-1:0]      hit_c, exp_c, free_c;
	logic              phit_c;
	logic [HOPS_W-1:0] hops_c;

	logic [FUNC_W-1:0] func_s1;
	logic [ID_W-1:0]   key_s1;
	logic              root_s1, conn_s1, phit_s1, empty_s1;
	logic [QUAL_W-1:0] qual_s1;
	logic [HOPS_W-1:0] hop_s1, hops_s1;
	logic [RSSI_W-1:0] rssi_s1;
	logic [N-1:0]      hit_s1, exp_s1, free_s1;
	logic [CNT_W-1:0]  removed_s1;

	// commit decode
	logic              hit_any, free_any;
	logic              do_ins, do_setdist, do_tick;
	logic [N-1:0]      wr_oh, valid_d;
	logic [CNT_W-1:0]  cnt_d;
	rsp_t              rsp_d;

	// aging reload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			reload_q <= AGING_RELOAD_RST;
		else if (cfg_write)
			reload_q <= cfg_data;
	end

	// parallel compare against all entries
	always_comb begin
		key_c    = req.node_id & ID_MASK;
		parent_c = req.parent_id & ID_MASK;
		hops_c   = '0;
		phit_c   = 1'b0;
		for (int i = 0; i < N; i++) begin
			hit_c[i] = valid_q[i] && (key_q[i] == key_c);
			exp_c[i] = valid_q[i] && (age_q[i] == '0);
			if (exp_c[i] && (key_q[i] == parent_c)) phit_c = 1'b1;
			if (hit_c[i]) hops_c = hops_c | hops_q[i];
		end
		// lowest free slot, one-hot
		free_c = ~valid_q & (valid_q + N'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_s1    <= req.func;
			key_s1     <= key_c;
			root_s1    <= req.is_root;
			conn_s1    <= req.is_joined;
			qual_s1    <= req.link_quality & QUAL_MASK;
			hop_s1     <= req.hop_distance;
			rssi_s1    <= req.signal_strength;
			hit_s1     <= hit_c;
			exp_s1     <= exp_c;
			free_s1    <= free_c;
			phit_s1    <= phit_c;
			hops_s1    <= hops_c;
			empty_s1   <= (cnt_q == '0);
			removed_s1 <= popcount(exp_c);
		end
	end

	// write-back decode and response build
	always_comb begin
		hit_any    = |hit_s1;
		free_any   = |free_s1;
		do_ins     = 1'b0;
		do_setdist = 1'b0;
		do_tick    = 1'b0;
		wr_oh      = hit_any ? hit_s1 : free_s1;
		valid_d    = valid_q;
		cnt_d      = cnt_q;
		rsp_d      = '0;
		unique case (func_s1)
			FUNC_INSERT: begin
				do_ins = 1'b1;
				if (hit_any) begin
					rsp_d.status = STAT_UPDATED;
					rsp_d.found  = 1'b1;
				end else if (free_any) begin
					rsp_d.status = STAT_ADDED;
					valid_d      = valid_q | free_s1;
					cnt_d        = cnt_q + CNT_W'(1);
				end else begin
					rsp_d.status = STAT_FULL;
				end
			end
			FUNC_REMOVE, FUNC_LOOKUP, FUNC_SETDIST: begin
				if (hit_any) begin
					rsp_d.status = STAT_UPDATED;
					rsp_d.found  = 1'b1;
					if (func_s1 == FUNC_REMOVE) begin
						valid_d = valid_q & ~hit_s1;
						cnt_d   = cnt_q - CNT_W'(1);
					end
					if (func_s1 == FUNC_LOOKUP) rsp_d.found_distance = hops_s1;
					if (func_s1 == FUNC_SETDIST) do_setdist = 1'b1;
				end else begin
					rsp_d.status = STAT_NOT_FOUND;
				end
			end
			FUNC_TICK: begin
				do_tick             = 1'b1;
				valid_d             = valid_q & ~exp_s1;
				cnt_d               = cnt_q - removed_s1;
				rsp_d.removed_count = CNTO_W'(removed_s1);
				rsp_d.lost_parent   = empty_s1 | phit_s1;
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = CNTO_W'(cnt_d);
	end

	// control state of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.commit) begin
			valid_q <= valid_d;
			cnt_q   <= cnt_d;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < N; i++) begin
				if (do_ins && wr_oh[i]) begin
					key_q[i]  <= key_s1;
					root_q[i] <= root_s1;
					conn_q[i] <= conn_s1;
					qual_q[i] <= qual_s1;
					hops_q[i] <= hop_s1;
					rssi_q[i] <= rssi_s1;
					age_q[i]  <= reload_q;
				end
				if (do_setdist && hit_s1[i]) hops_q[i] <= hop_s1;
				if (do_tick && valid_q[i] && !exp_s1[i]) age_q[i] <= age_q[i] - AGE_W'(1);
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.commit) rsp <= rsp_d;
	end

endmodule

FILE: hdl/neighbor_table_with_aging.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Bounded neighbor table keyed by node id with insert, remove, lookup,
// set distance and an aging tick that expires stale entries.
//
//   channel   signals                        direction
//   req       req_valid, req_stall, req      in  (one operation per transaction)
//   rsp       rsp_valid, rsp_stall, rsp      out (one result per transaction)
//   cfg       cfg_valid, cfg_ready, cfg_data in  (aging reload count)
//
// Each operation runs as capture then commit: the capture edge matches the id
// against every entry in parallel and registers the result; the commit edge
// updates the table and loads the response register.
// Reset empties the table (valid bits cleared) and sets the reload to 3.
// A stalled response holds the write-back; the next request is taken once
// the response register has been loaded.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging
	import ntwa_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int ID_BYTES      = 6,
	parameter int QUALITY_BYTES = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [AGE_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// sequencer
	ntwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// table and datapath
	ntwa_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ID_BYTES      (ID_BYTES),
		.QUALITY_BYTES (QUALITY_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_write (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule

FILE: tb/neighbor_table_with_aging_test.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_test
// Self-checking bench for the neighbor table. A scoreboard tracks its own copy
// of the table and the aging reload, predicts the response of every accepted
// request and compares each response field by field. A directed sequence
// covers edge cases, followed by random operations over a small id pool,
// across several reload settings with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_test;
	import ntwa_pkg::*;

	localparam int TABLE_SLOTS = 16;
	localparam int POOL_SIZE   = 20;
	localparam logic [FUNC_W-1:0] FUNC_FIRST_SPARE = FUNC_TICK + 1'b1;
	localparam logic [FUNC_W-1:0] FUNC_LAST_SPARE  = '1;

	// table tracker and response checker
	class neighbor_scoreboard;
		bit                slot_used [TABLE_SLOTS];
		logic [ID_W-1:0]   slot_id   [TABLE_SLOTS];
		logic [HOPS_W-1:0] slot_hops [TABLE_SLOTS];
		logic [AGE_W-1:0]  slot_age  [TABLE_SLOTS];
		logic [AGE_W-1:0]  age_reload;
		rsp_t              expected_results[$];
		int                error_count;

		function new();
			age_reload = AGING_RELOAD_RST;
			error_count = 0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		function int find_id(logic [ID_W-1:0] id);
			for (int i = 0; i < TABLE_SLOTS; i++)
				if (slot_used[i] && slot_id[i] == id) return i;
			return -1;
		endfunction

		function int occupied();
			int n;
			n = 0;
			foreach (slot_used[i]) if (slot_used[i]) n++;
			return n;
		endfunction

		// apply one accepted request and queue the response it must produce
		function void note_request(req_t r);
			rsp_t e;
			int   slot;
			e = '0;
			case (r.func)
				FUNC_INSERT: begin
					slot = find_id(r.node_id);
					if (slot >= 0) begin
						e.status = STAT_UPDATED;
						e.found = 1'b1;
					end else begin
						for (int i = 0; i < TABLE_SLOTS; i++)
							if (!slot_used[i] && slot < 0) slot = i;
						e.status = (slot >= 0) ? STAT_ADDED : STAT_FULL;
					end
					if (slot >= 0) begin
						slot_used[slot] = 1'b1;
						slot_id[slot]   = r.node_id;
						slot_hops[slot] = r.hop_distance;
						slot_age[slot]  = age_reload;
					end
				end
				FUNC_REMOVE, FUNC_LOOKUP, FUNC_SETDIST: begin
					slot = find_id(r.node_id);
					if (slot < 0) begin
						e.status = STAT_NOT_FOUND;
					end else begin
						e.status = STAT_UPDATED;
						e.found = 1'b1;
						if (r.func == FUNC_REMOVE) slot_used[slot] = 1'b0;
						else if (r.func == FUNC_LOOKUP) e.found_distance = slot_hops[slot];
						else slot_hops[slot] = r.hop_distance;
					end
				end
				FUNC_TICK: begin
					// empty table counts as a lost parent
					if (occupied() == 0) begin
						e.lost_parent = 1'b1;
					end else begin
						for (int i = 0; i < TABLE_SLOTS; i++) begin
							if (slot_used[i]) begin
								if (slot_age[i] == '0) begin
									slot_used[i] = 1'b0;
									e.removed_count = e.removed_count + 1'b1;
									if (slot_id[i] == r.parent_id) e.lost_parent = 1'b1;
								end else begin
									slot_age[i] = slot_age[i] - 1'b1;
								end
							end
						end
					end
				end
				default: ;
			endcase
			e.entry_count = CNTO_W'(occupied());
			expected_results.push_back(e);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				error_count++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %p", $time, got);
				error_count++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("found", want.found, got.found);
			compare_field("found_distance", want.found_distance, got.found_distance);
			compare_field("removed_count", want.removed_count, got.removed_count);
			compare_field("lost_parent", want.lost_parent, got.lost_parent);
			compare_field("entry_count", want.entry_count, got.entry_count);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [AGE_W-1:0] cfg_data;

	neighbor_scoreboard sb = new();
	logic [ID_W-1:0]    id_pool [POOL_SIZE];
	bit                 sender_steady;
	int                 results_taken;

	neighbor_table_with_aging dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [ID_W-1:0] random_id();
		return ID_W'({$urandom, $urandom});
	endfunction

	// request with the fields the operation ignores filled at random
	function automatic req_t compose(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
			logic [HOPS_W-1:0] hops, logic [ID_W-1:0] parent);
		req_t r;
		r.func            = f;
		r.node_id         = id;
		r.is_root         = 1'($urandom_range(0, 1));
		r.is_joined       = 1'($urandom_range(0, 1));
		r.link_quality    = QUAL_W'($urandom);
		r.hop_distance    = hops;
		r.signal_strength = RSSI_W'($urandom);
		r.parent_id       = parent;
		return r;
	endfunction

	// offer one request transaction after a random gap, hold it until taken
	task automatic send_request(input req_t r);
		int gap;
		if ($urandom_range(0, 19) == 0) sender_steady = !sender_steady;
		gap = sender_steady ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	// reload write once the table has gone quiet
	task automatic change_reload(input logic [AGE_W-1:0] value);
		stop_requests();
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.age_reload = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// edge cases: empty tick, field extremes, hit and miss of each lookup
	// style operation, unused codes, full table and a mass expiry of the parent
	task automatic run_directed();
		req_t            r;
		logic [ID_W-1:0] ones;
		ones = '1;
		send_request(compose(FUNC_TICK, ones, '0, '0));
		r = compose(FUNC_INSERT, ones, '1, ones);
		r.is_root = 1'b1;
		r.is_joined = 1'b1;
		r.link_quality = '1;
		r.signal_strength = 8'sd127;
		send_request(r);
		r = compose(FUNC_INSERT, '0, '0, '0);
		r.is_root = 1'b0;
		r.is_joined = 1'b0;
		r.link_quality = '0;
		r.signal_strength = -8'sd128;
		send_request(r);
		send_request(compose(FUNC_INSERT, ones, 8'h55, '0));
		send_request(compose(FUNC_LOOKUP, ones, '0, '0));
		send_request(compose(FUNC_LOOKUP, id_pool[POOL_SIZE-1], '0, '0));
		send_request(compose(FUNC_SETDIST, '0, 8'hAA, '0));
		send_request(compose(FUNC_SETDIST, id_pool[POOL_SIZE-1], 8'h11, '0));
		send_request(compose(FUNC_LOOKUP, '0, '0, '0));
		send_request(compose(FUNC_REMOVE, '0, '0, '0));
		send_request(compose(FUNC_REMOVE, id_pool[POOL_SIZE-1], '0, '0));
		send_request(compose(FUNC_FIRST_SPARE, ones, '1, ones));
		send_request(compose(FUNC_LAST_SPARE, '0, '0, '0));
		// fill the table, last insert finds it full
		for (int i = 0; i < TABLE_SLOTS; i++)
			send_request(compose(FUNC_INSERT, id_pool[i], HOPS_W'($urandom), '0));
		// reload is still at its reset value: the fourth tick expires everything
		for (int i = 0; i < 4; i++)
			send_request(compose(FUNC_TICK, random_id(), '0, id_pool[3]));
	endtask

	// random operations over the id pool with some stray ids
	task automatic run_random(input int count);
		int                pick;
		logic [FUNC_W-1:0] f;
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   parent;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 34) f = FUNC_INSERT;
			else if (pick < 44) f = FUNC_REMOVE;
			else if (pick < 64) f = FUNC_LOOKUP;
			else if (pick < 76) f = FUNC_SETDIST;
			else if (pick < 97) f = FUNC_TICK;
			else f = FUNC_W'($urandom_range(FUNC_FIRST_SPARE, FUNC_LAST_SPARE));
			id = ($urandom_range(0, 9) == 0) ? random_id() : id_pool[$urandom_range(0, POOL_SIZE-1)];
			parent = ($urandom_range(0, 9) < 6) ? id_pool[$urandom_range(0, POOL_SIZE-1)]
				: random_id();
			send_request(compose(f, id, HOPS_W'($urandom), parent));
		end
	endtask

	// response side: random stalls, two long hold-offs to back up the block
	initial begin : result_sink
		int hold;
		bit steady;
		rsp_stall = 1'b1;
		steady = 1'b0;
		results_taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 19) == 0) steady = !steady;
			hold = steady ? 0 : $urandom_range(0, 14);
			if (results_taken == 500 || results_taken == 1300) hold = 250;
			if (hold > 0) begin
				rsp_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall = 1'b0;
			do @(posedge clk); while (!rsp_valid);
			sb.check_result(rsp);
			results_taken++;
		end
	end

	// main sequence
	initial begin : stimulus
		int waited;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		sender_steady = 1'b0;
		foreach (id_pool[i]) id_pool[i] = random_id();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random(360);
		change_reload('0);
		run_random(360);
		change_reload('1);
		run_random(360);
		change_reload(AGE_W'(1));
		run_random(360);
		change_reload(AGE_W'($urandom_range(2, 12)));
		run_random(360);
		stop_requests();

		// drain outstanding responses
		waited = 0;
		while (sb.expected_results.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.expected_results.size() != 0) begin
			$display("%0t: %0d responses missing, expected %0d, actual 0", $time,
				sb.expected_results.size(), sb.expected_results.size());
			sb.error_count += sb.expected_results.size();
		end
		repeat (8) @(posedge clk);
		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/ntwa_pkg.sv
hdl/ntwa_ctrl.sv
hdl/ntwa_dpath.sv
hdl/neighbor_table_with_aging.sv
tb/neighbor_table_with_aging_test.sv
